[rtl/core/sbws_pkg.sv]
// ----------------------------------------------------------------------------
// sbws_pkg
// Shared types and constants of the strongest beacon window selector.
// ----------------------------------------------------------------------------
package sbws_pkg;

  localparam int unsigned MAX_SESSION_DEF  = 8;
  localparam int unsigned MAX_SESSION_LOW  = 2;
  localparam int unsigned MAX_SESSION_HIGH = 32;

  localparam int unsigned MAJOR_W   = 16;
  localparam int unsigned MINOR_W   = 16;
  localparam int unsigned RSSI_W    = 8;
  localparam int unsigned UUID_W    = 64;
  localparam int unsigned KEY_W     = MAJOR_W + MINOR_W;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned SESS_LEN_W = 4;

  localparam logic [SESS_LEN_W-1:0] SESSION_LENGTH_RST = SESS_LEN_W'(5);

  // APB register map: one 32-bit register per word
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_SESSION_LENGTH = 1'b0;

  typedef struct packed {
    logic [MAJOR_W-1:0]       major;
    logic [MINOR_W-1:0]       minor;
    logic signed [RSSI_W-1:0] rssi;
    logic [UUID_W-1:0]        uuid_high;
    logic [UUID_W-1:0]        uuid_low;
  } beacon_t;

  // control from the sequencer to the best-beacon holder
  typedef struct packed {
    logic take;   // a new distinct beacon is being counted
    logic first;  // it is the first of the session
  } best_ctrl_t;

endpackage

[rtl/core/strongest_beacon_window_select.sv]
// ----------------------------------------------------------------------------
// strongest_beacon_window_select
// Groups beacon reports into sessions and reports the strongest distinct one.
// ----------------------------------------------------------------------------
// Each report is taken in the idle state, then the keys already counted in
// the session are read out of the key table one per cycle until one matches,
// and the update state writes back and updates the best beacon. The single
// read port of the key table sets the pace of the scan. At the last report
// of a session the block stalls in its update state only while a previous
// result still waits in the output register. session_length keeps the low
// 4 bits of a write and reads them back; 0 acts as 1 and values above
// MaxSession act as MaxSession. A result carries the first-seen strength of
// the strongest distinct beacon and the distinct count, and the session
// starts afresh.
// ----------------------------------------------------------------------------
module strongest_beacon_window_select #(
  parameter int unsigned MaxSession = sbws_pkg::MAX_SESSION_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // report input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sbws_pkg::MAJOR_W-1:0]        report_major_i,
  input  logic [sbws_pkg::MINOR_W-1:0]        report_minor_i,
  input  logic signed [sbws_pkg::RSSI_W-1:0]  report_rssi_i,
  input  logic [sbws_pkg::UUID_W-1:0]         report_uuid_high_i,
  input  logic [sbws_pkg::UUID_W-1:0]         report_uuid_low_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sbws_pkg::MAJOR_W-1:0]        beacon_major_o,
  output logic [sbws_pkg::MINOR_W-1:0]        beacon_minor_o,
  output logic signed [sbws_pkg::RSSI_W-1:0]  beacon_rssi_o,
  output logic [sbws_pkg::UUID_W-1:0]         beacon_uuid_high_o,
  output logic [sbws_pkg::UUID_W-1:0]         beacon_uuid_low_o,
  output logic [sbws_pkg::COUNT_W-1:0]        distinct_count_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbws_pkg::PADDR_W-1:0]        paddr,
  input  logic [sbws_pkg::PDATA_W-1:0]        pwdata,
  output logic [sbws_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int unsigned IdxW = $clog2(MaxSession);
  localparam int unsigned CntW = $clog2(MaxSession + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [sbws_pkg::SESS_LEN_W-1:0] session_length_q;
  logic [sbws_pkg::SESS_LEN_W-1:0] session_length_d;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    session_length_d = session_length_q;
    prdata           = '0;
    unique case (paddr[2])
      sbws_pkg::REG_SESSION_LENGTH: begin
        prdata = sbws_pkg::PDATA_W'(session_length_q);
        if (cfg_write) begin
          session_length_d = pwdata[sbws_pkg::SESS_LEN_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_length_q <= sbws_pkg::SESSION_LENGTH_RST;
    end else begin
      session_length_q <= session_length_d;
    end
  end

  logic [CntW-1:0] eff_len;

  always_comb begin
    if (session_length_q == '0) begin
      eff_len = CntW'(1);
    end else if (32'(session_length_q) > 32'(MaxSession)) begin
      eff_len = CntW'(MaxSession);
    end else begin
      eff_len = CntW'(session_length_q);
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  state_e                          state_q, state_d;
  logic [CntW-1:0]                 report_counter_q, report_counter_d;
  logic [CntW-1:0]                 seen_total_q, seen_total_d;
  logic [CntW-1:0]                 rd_idx_q, rd_idx_d;
  logic                            cmp_valid_q, cmp_valid_d;
  logic                            found_q, found_d;
  sbws_pkg::beacon_t               cur_q, cur_d;
  logic                            out_valid_q, out_valid_d;
  sbws_pkg::beacon_t               out_q, out_d;
  logic [sbws_pkg::COUNT_W-1:0]    count_q, count_d;

  logic [sbws_pkg::KEY_W-1:0]      cur_key;
  logic [sbws_pkg::KEY_W-1:0]      rdata;
  logic                            issue;
  logic                            hit;
  logic                            is_new;
  logic [CntW-1:0]                 cnt_next;
  logic [CntW-1:0]                 seen_next;
  logic                            done;
  logic                            fire;
  logic                            emit;
  logic [31:0]                     seen_wide;
  sbws_pkg::best_ctrl_t            best_ctrl;
  sbws_pkg::beacon_t               best;

  assign cur_key   = {cur_q.major, cur_q.minor};
  assign issue     = (state_q == ST_SCAN) && (rd_idx_q < seen_total_q);
  assign hit       = cmp_valid_q && (rdata == cur_key);
  assign is_new    = !found_q && (seen_total_q < CntW'(MaxSession));
  assign cnt_next  = report_counter_q + CntW'(1);
  assign seen_next = is_new ? seen_total_q + CntW'(1) : seen_total_q;
  assign done      = cnt_next >= eff_len;
  // hold the last update of a session while the previous result has not been taken
  assign fire      = (state_q == ST_UPDATE) && (!done || !out_valid_q || out_ready_i);
  assign emit      = fire && done;
  assign seen_wide = 32'(seen_next);

  assign best_ctrl.take  = fire && is_new;
  assign best_ctrl.first = (seen_total_q == '0);

  always_comb begin
    state_d          = state_q;
    report_counter_d = report_counter_q;
    seen_total_d     = seen_total_q;
    rd_idx_d         = rd_idx_q;
    cmp_valid_d      = 1'b0;
    found_d          = found_q;
    cur_d            = cur_q;
    out_d            = out_q;
    count_d          = count_q;
    out_valid_d      = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cur_d.major     = report_major_i;
          cur_d.minor     = report_minor_i;
          cur_d.rssi      = report_rssi_i;
          cur_d.uuid_high = report_uuid_high_i;
          cur_d.uuid_low  = report_uuid_low_i;
          rd_idx_d        = '0;
          found_d         = 1'b0;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        cmp_valid_d = issue;
        if (hit) begin
          found_d     = 1'b1;
          cmp_valid_d = 1'b0;
          state_d     = ST_UPDATE;
        end else if (!issue) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (fire) begin
          state_d = ST_IDLE;
          if (done) begin
            out_d            = best;
            count_d          = seen_wide[sbws_pkg::COUNT_W-1:0];
            out_valid_d      = 1'b1;
            report_counter_d = '0;
            seen_total_d     = '0;
          end else begin
            report_counter_d = cnt_next;
            seen_total_d     = seen_next;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      report_counter_q <= '0;
      seen_total_q     <= '0;
      rd_idx_q         <= '0;
      cmp_valid_q      <= 1'b0;
      found_q          <= 1'b0;
      cur_q            <= '0;
      out_valid_q      <= 1'b0;
      out_q            <= '0;
      count_q          <= '0;
    end else begin
      state_q          <= state_d;
      report_counter_q <= report_counter_d;
      seen_total_q     <= seen_total_d;
      rd_idx_q         <= rd_idx_d;
      cmp_valid_q      <= cmp_valid_d;
      found_q          <= found_d;
      cur_q            <= cur_d;
      out_valid_q      <= out_valid_d;
      out_q            <= out_d;
      count_q          <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // key table and best beacon
  // --------------------------------------------------------------------------
  sbws_key_mem #(
    .Depth (MaxSession),
    .IdxW  (IdxW)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (best_ctrl.take),
    .waddr_i (seen_total_q[IdxW-1:0]),
    .wdata_i (cur_key),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  sbws_best_hold u_best_hold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (best_ctrl),
    .cand_i (cur_q),
    .best_o (best)
  );

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign beacon_major_o     = out_q.major;
  assign beacon_minor_o     = out_q.minor;
  assign beacon_rssi_o      = out_q.rssi;
  assign beacon_uuid_high_o = out_q.uuid_high;
  assign beacon_uuid_low_o  = out_q.uuid_low;
  assign distinct_count_o   = count_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_seen_le_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_total_q <= report_counter_q)
    else $error("distinct count exceeds report count");

  a_counter_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_counter_q < CntW'(MaxSession))
    else $error("report counter passed the session limit");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> seen_next != '0)
    else $error("result posted with no beacon counted");

  a_session_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (report_counter_q == '0) && (seen_total_q == '0) && out_valid_q)
    else $error("session not cleared after result");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> rd_idx_q <= seen_total_q)
    else $error("key scan ran past the counted entries");

endmodule

[rtl/core/sbws_key_mem.sv]
// ----------------------------------------------------------------------------
// sbws_key_mem
// Table of major/minor keys seen in the current session: one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module sbws_key_mem #(
  parameter int unsigned Depth = sbws_pkg::MAX_SESSION_DEF,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [IdxW-1:0]            waddr_i,
  input  logic [sbws_pkg::KEY_W-1:0] wdata_i,
  input  logic [IdxW-1:0]            raddr_i,
  output logic [sbws_pkg::KEY_W-1:0] rdata_o
);

  logic [sbws_pkg::KEY_W-1:0] mem [Depth];
  logic [sbws_pkg::KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sbws_best_hold.sv]
// ----------------------------------------------------------------------------
// sbws_best_hold
// Holds the strongest counted beacon of the session and presents the
// merged view with the beacon currently being counted.
// ----------------------------------------------------------------------------
module sbws_best_hold (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbws_pkg::best_ctrl_t ctrl_i,
  input  sbws_pkg::beacon_t    cand_i,
  output sbws_pkg::beacon_t    best_o
);

  sbws_pkg::beacon_t best_q;
  logic              stronger;
  logic              load;

  // strictly stronger only, so the earliest beacon keeps a tie
  assign stronger = $signed(cand_i.rssi) > $signed(best_q.rssi);
  assign load     = ctrl_i.take && (ctrl_i.first || stronger);
  assign best_o   = load ? cand_i : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (load) begin
      best_q <= cand_i;
    end
  end

endmodule
